>>> hw/rtl/spcp_pkg.sv
// shared types, constants and helpers for the shape pair collision block
package spcp_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ID_WIDTH_DEF = 16;

	// front to back queue
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	// rounded divider: quotient bits, remainder width, step counter width
	localparam int QB = 19;
	localparam int DW = 38;
	localparam int CNTW = $clog2(QB);

	// pair kinds
	localparam logic [1:0] FN_SS = 2'd0;
	localparam logic [1:0] FN_BB = 2'd1;
	localparam logic [1:0] FN_BS = 2'd2;
	localparam logic [1:0] FN_SB = 2'd3;

	typedef enum logic [1:0] {
		RK_DIRECT,
		RK_RADIAL,
		RK_AXIS
	} rec_kind_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [47:0] a_lo;
		logic [47:0] a_hi;
		logic [47:0] b_lo;
		logic [47:0] b_hi;
		logic        a_pushes;
		logic        b_pushes;
		logic [15:0] a_id;
		logic [15:0] b_id;
	} item_t;

	typedef struct packed {
		logic               hit;
		logic               has_info;
		logic               for_side;
		logic [15:0]        other_id;
		logic signed [15:0] push_x;
		logic signed [15:0] push_y;
		logic signed [15:0] push_z;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic               last;
	} result_t;

	// one push-back record as classified by the front
	typedef struct packed {
		rec_kind_t        kind;
		logic             side;
		logic [15:0]      oid;
		logic [2:0][16:0] v;     // radial direction vector, signed lanes
		logic [2:0][15:0] base;  // radial base point, or final contact point
		logic [15:0]      rr;    // radial radius
		logic [2:0][15:0] dp;    // final push for box-box records
		logic [1:0]       ax;    // axis record: push axis
		logic             pos;   // axis record: push is positive
	} rec_t;

	typedef struct packed {
		logic            hit;
		logic [1:0]      nrec;
		logic            half;
		logic            need_len;
		logic [33:0]     d2;
		logic [16:0]     rsum;
		rec_t [1:0]      rec;
	} job_t;

	function automatic logic [15:0] sat16(input logic signed [23:0] v);
		if (v > 24'sd32767) return 16'h7fff;
		if (v < -24'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	// halving with round to nearest, ties away from zero, when half is set
	function automatic logic signed [17:0] half_rnd(input logic signed [17:0] x,
			input logic half);
		logic signed [17:0] m;
		if (!half) return x;
		if (x < 0) begin
			m = -x;
			m = (m + 18'sd1) >>> 1;
			return -m;
		end
		m = (x + 18'sd1) >>> 1;
		return m;
	endfunction

endpackage

>>> hw/rtl/spcp_front.sv
// front end: lane decode, classification, squared distances, record setup
module spcp_front import spcp_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ID_WIDTH = ID_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  item_t      item,
	output logic       push,
	output job_t       job,
	output logic [1:0] inflight
);

	localparam int CW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
	localparam int CSH = 16 - CW;
	localparam int IDW = (ID_WIDTH < 16) ? ID_WIDTH : 16;
	localparam int ISH = 16 - IDW;

	typedef struct packed {
		logic [1:0]       func;
		logic             ap;
		logic             bp;
		logic [15:0]      aid;
		logic [15:0]      bid;
		logic [2:0][16:0] d;
		logic [2:0][15:0] base0;
		logic [2:0][15:0] base1;
		logic [15:0]      rr0;
		logic [15:0]      rr1;
		logic [16:0]      rsum;
		logic             bb_hit;
		logic [2:0][15:0] bb_pa;
		logic [2:0][15:0] bb_pb;
		logic [2:0][15:0] bb_q;
		logic [1:0]       ax;
		logic             pos;
	} s1_t;

	function automatic logic signed [15:0] lane_f(input logic [47:0] v, input int i);
		logic [15:0] raw;
		raw = v[16*i +: 16];
		return $signed(raw << CSH) >>> CSH;
	endfunction

	logic signed [15:0] alo[3], ahi[3], blo[3], bhi[3];
	logic signed [15:0] mn[3], mx[3], cc[3], cl[3], omin[3], omax[3];
	logic signed [16:0] ov[3], dv[3], sa[3], sb[3];
	logic [16:0]        ab[3];
	logic [15:0]        ra, rb, rsp;
	logic               boxa, half_a;
	logic [1:0]         bax;
	logic signed [17:0] mag, pa, qh;
	s1_t                s1_n, pay_s1, pay_s2;
	logic               valid_s1, valid_s2;
	logic [2:0][33:0]   sq_s2;
	logic [33:0]        rsq_s2;
	logic signed [33:0] sqs[3];

	// stage 1: decode lanes and do everything that needs no multiply
	always_comb begin
		s1_n = '0;
		ra = item.a_hi[15:0] & (16'hffff >> CSH);
		rb = item.b_hi[15:0] & (16'hffff >> CSH);
		boxa = (item.func == FN_BS);
		rsp = boxa ? rb : ra;
		half_a = item.a_pushes & item.b_pushes;
		s1_n.bb_hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			alo[i] = lane_f(item.a_lo, i);
			ahi[i] = lane_f(item.a_hi, i);
			blo[i] = lane_f(item.b_lo, i);
			bhi[i] = lane_f(item.b_hi, i);
			// box-sphere: clamp centre into box, lower bound first
			mn[i] = boxa ? alo[i] : blo[i];
			mx[i] = boxa ? ahi[i] : bhi[i];
			cc[i] = boxa ? blo[i] : alo[i];
			cl[i] = (cc[i] < mn[i]) ? mn[i] : ((cc[i] > mx[i]) ? mx[i] : cc[i]);
			if (item.func == FN_SS) begin
				dv[i] = 17'(alo[i]) - 17'(blo[i]);
				s1_n.base0[i] = alo[i];
				s1_n.base1[i] = blo[i];
			end else begin
				dv[i] = 17'(cl[i]) - 17'(cc[i]);
				s1_n.base0[i] = cc[i];
				s1_n.base1[i] = cl[i];
			end
			s1_n.d[i] = dv[i];
			ab[i] = dv[i][16] ? 17'(-dv[i]) : 17'(dv[i]);
			// box-box overlap
			if (ahi[i] < blo[i] || alo[i] > bhi[i])
				s1_n.bb_hit = 1'b0;
			omin[i] = (alo[i] > blo[i]) ? alo[i] : blo[i];
			omax[i] = (ahi[i] < bhi[i]) ? ahi[i] : bhi[i];
			ov[i] = 17'(omax[i]) - 17'(omin[i]);
			sa[i] = 17'(alo[i]) + 17'(ahi[i]);
			sb[i] = 17'(blo[i]) + 17'(bhi[i]);
			qh = 18'(omin[i]) + half_rnd(18'(ov[i]), half_a);
			s1_n.bb_q[i] = sat16(24'(qh));
		end
		// least overlap axis, ties to the lower axis
		bax = 2'd0;
		if (ov[1] < ov[bax]) bax = 2'd1;
		if (ov[2] < ov[bax]) bax = 2'd2;
		mag = half_rnd(18'(ov[bax]), half_a);
		pa = (sa[bax] < sb[bax]) ? -mag : mag;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) == bax) begin
				s1_n.bb_pa[i] = sat16(24'(pa));
				s1_n.bb_pb[i] = sat16(-24'(pa));
			end
		end
		// sphere push axis: largest offset, ties x then y
		if (ab[0] >= ab[1] && ab[0] >= ab[2])
			s1_n.ax = 2'd0;
		else if (ab[1] >= ab[2])
			s1_n.ax = 2'd1;
		else
			s1_n.ax = 2'd2;
		s1_n.pos = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) == s1_n.ax)
				s1_n.pos = dv[i][16];
		end
		s1_n.func = item.func;
		s1_n.ap = item.a_pushes;
		s1_n.bp = item.b_pushes;
		s1_n.aid = item.a_id & (16'hffff >> ISH);
		s1_n.bid = item.b_id & (16'hffff >> ISH);
		s1_n.rr0 = (item.func == FN_SS) ? ra : rsp;
		s1_n.rr1 = (item.func == FN_SS) ? rb : rsp;
		s1_n.rsum = (item.func == FN_SS) ? (17'(ra) + 17'(rb)) : 17'(rsp);
	end

	// stage 2: squares
	always_comb begin
		for (int i = 0; i < 3; i++)
			sqs[i] = $signed(pay_s1.d[i]) * $signed(pay_s1.d[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pay_s1 <= s1_n;
		if (valid_s1) begin
			pay_s2 <= pay_s1;
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= sqs[i];
			rsq_s2 <= pay_s1.rsum * pay_s1.rsum;
		end
	end

	// hit test and record ordering
	rec_t        c0, c1;
	logic        pr0, pr1, hit;
	logic [33:0] d2;

	always_comb begin
		c0 = '0;
		c1 = '0;
		d2 = sq_s2[0] + sq_s2[1] + sq_s2[2];
		hit = (pay_s2.func == FN_BB) ? pay_s2.bb_hit : (d2 < rsq_s2);
		case (pay_s2.func)
			FN_SS: begin
				c0.kind = RK_RADIAL;
				c0.side = 1'b0;
				c0.oid = pay_s2.bid;
				c0.v = pay_s2.d;
				c0.base = pay_s2.base0;
				c0.rr = pay_s2.rr0;
				c1.kind = RK_RADIAL;
				c1.side = 1'b1;
				c1.oid = pay_s2.aid;
				for (int i = 0; i < 3; i++)
					c1.v[i] = 17'(-$signed(pay_s2.d[i]));
				c1.base = pay_s2.base1;
				c1.rr = pay_s2.rr1;
				pr0 = pay_s2.ap;
				pr1 = pay_s2.bp;
			end
			FN_BB: begin
				c0.kind = RK_DIRECT;
				c0.side = 1'b0;
				c0.oid = pay_s2.bid;
				c0.dp = pay_s2.bb_pa;
				c0.base = pay_s2.bb_q;
				c1.kind = RK_DIRECT;
				c1.side = 1'b1;
				c1.oid = pay_s2.aid;
				c1.dp = pay_s2.bb_pb;
				c1.base = pay_s2.bb_q;
				pr0 = pay_s2.ap;
				pr1 = pay_s2.bp;
			end
			default: begin
				// box record first, then the sphere record
				c0.kind = RK_RADIAL;
				c0.side = (pay_s2.func != FN_BS);
				c0.oid = (pay_s2.func == FN_BS) ? pay_s2.bid : pay_s2.aid;
				c0.v = pay_s2.d;
				c0.base = pay_s2.base0;
				c0.rr = pay_s2.rr0;
				c1.kind = RK_AXIS;
				c1.side = (pay_s2.func == FN_BS);
				c1.oid = (pay_s2.func == FN_BS) ? pay_s2.aid : pay_s2.bid;
				c1.base = pay_s2.base1;
				c1.ax = pay_s2.ax;
				c1.pos = pay_s2.pos;
				pr0 = (pay_s2.func == FN_BS) ? pay_s2.ap : pay_s2.bp;
				pr1 = (pay_s2.func == FN_BS) ? pay_s2.bp : pay_s2.ap;
			end
		endcase
		if (!hit) begin
			pr0 = 1'b0;
			pr1 = 1'b0;
		end
		job.hit = hit;
		job.nrec = {1'b0, pr0} + {1'b0, pr1};
		job.half = pay_s2.ap & pay_s2.bp;
		job.need_len = (pay_s2.func != FN_BB);
		job.d2 = d2;
		job.rsum = pay_s2.rsum;
		job.rec[0] = pr0 ? c0 : c1;
		job.rec[1] = c1;
	end

	assign push = valid_s2;
	assign inflight = {1'b0, valid_s1} + {1'b0, valid_s2};

endmodule

>>> hw/rtl/spcp_queue.sv
// small register queue of classified jobs between front and back
module spcp_queue import spcp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  job_t           wdata,
	input  logic           pop,
	output job_t           rdata,
	output logic           empty,
	output logic [QCW-1:0] count
);

	job_t           mem[QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wdata;
	end

	assign rdata = mem[rp_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

>>> hw/rtl/spcp_back.sv
// back end: square root, rounded divisions and record output
module spcp_back import spcp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    empty,
	input  job_t    rdata,
	output logic    pop,
	output logic    done,
	output result_t result
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SQRT = 7'b0000010,
		ST_PICK = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_LOAD = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t             state_q, state_n;
	job_t               job_q;
	logic               ri_q;
	logic [CNTW-1:0]    cnt_q;
	logic [16:0]        len_q;
	logic [33:0]        sv_q, sv_n, sbit_q;
	logic [34:0]        sres_q, sres_n, tsum;
	logic               sge;
	logic signed [35:0] prod_q[6];
	logic signed [35:0] prod_n[6];
	logic [DW-1:0]      rem_q[6], dsh_q[6];
	logic [QB-1:0]      quo_q[6];
	logic               neg_q[6];
	logic               done_q;
	result_t            res_q, e_res;
	logic               emit, last_rec;
	rec_t               cur;
	logic signed [17:0] ov_s, m_ax;
	logic [15:0]        pv[3], qv[3];
	logic signed [19:0] sval[6];
	logic [35:0]        mag[6];
	logic [17:0]        dvs[6];

	assign cur = job_q.rec[ri_q];
	assign last_rec = ri_q || (job_q.nrec == 2'd1);
	assign ov_s = $signed({1'b0, job_q.rsum}) - $signed({1'b0, len_q});
	assign m_ax = half_rnd(ov_s, job_q.half);

	// one square root digit per cycle
	assign tsum = sres_q + 35'(sbit_q);
	assign sge = {1'b0, sv_q} >= tsum;
	assign sv_n = sge ? (sv_q - tsum[33:0]) : sv_q;
	assign sres_n = sge ? ((sres_q >> 1) + 35'(sbit_q)) : (sres_q >> 1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_n[i] = $signed(cur.v[i]) * ov_s;
			prod_n[i+3] = $signed(cur.v[i]) * $signed({1'b0, cur.rr});
		end
		for (int i = 0; i < 6; i++) begin
			mag[i] = prod_q[i][35] ? 36'(-prod_q[i]) : 36'(prod_q[i]);
			dvs[i] = (i < 3 && job_q.half) ? {len_q, 1'b0} : {1'b0, len_q};
			sval[i] = neg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
		end
	end

	// result assembly
	always_comb begin
		emit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			pv[i] = '0;
			qv[i] = '0;
		end
		e_res = '0;
		e_res.hit = 1'b1;
		e_res.has_info = 1'b1;
		e_res.for_side = cur.side;
		e_res.other_id = cur.oid;
		e_res.last = last_rec;
		case (state_q)
			ST_IDLE: begin
				if (!empty && rdata.nrec == 2'd0) begin
					emit = 1'b1;
					e_res.hit = rdata.hit;
					e_res.has_info = 1'b0;
					e_res.for_side = 1'b0;
					e_res.other_id = '0;
					e_res.last = 1'b1;
				end
			end
			ST_PICK: begin
				case (cur.kind)
					RK_DIRECT: begin
						emit = 1'b1;
						for (int i = 0; i < 3; i++) begin
							pv[i] = cur.dp[i];
							qv[i] = cur.base[i];
						end
					end
					RK_AXIS: begin
						emit = 1'b1;
						for (int i = 0; i < 3; i++) begin
							qv[i] = cur.base[i];
							if (2'(i) == cur.ax)
								pv[i] = sat16(cur.pos ? 24'(m_ax) : -24'(m_ax));
						end
					end
					RK_RADIAL: begin
						// coincident points: zero direction
						if (len_q == '0) begin
							emit = 1'b1;
							for (int i = 0; i < 3; i++)
								qv[i] = cur.base[i];
						end
					end
					default: emit = 1'b1;
				endcase
			end
			ST_OUT: begin
				emit = 1'b1;
				for (int i = 0; i < 3; i++) begin
					pv[i] = sat16(24'(sval[i]));
					qv[i] = sat16(24'($signed(cur.base[i])) + 24'(sval[i+3]));
				end
			end
			default: ;
		endcase
		e_res.push_x = pv[0];
		e_res.push_y = pv[1];
		e_res.push_z = pv[2];
		e_res.point_x = qv[0];
		e_res.point_y = qv[1];
		e_res.point_z = qv[2];
	end

	always_comb begin
		state_n = state_q;
		pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = !empty;
				if (!empty && rdata.nrec != 2'd0)
					state_n = rdata.need_len ? ST_SQRT : ST_PICK;
			end
			ST_SQRT: if (sbit_q == 34'd1) state_n = ST_PICK;
			ST_PICK: begin
				if (emit)
					state_n = last_rec ? ST_IDLE : ST_PICK;
				else
					state_n = ST_MUL;
			end
			ST_MUL:  state_n = ST_LOAD;
			ST_LOAD: state_n = ST_DIV;
			ST_DIV:  if (cnt_q == '0) state_n = ST_OUT;
			ST_OUT:  state_n = last_rec ? ST_IDLE : ST_PICK;
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ri_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q <= emit;
			if (pop)
				ri_q <= 1'b0;
			else if (emit && !last_rec && (state_q == ST_PICK || state_q == ST_OUT))
				ri_q <= 1'b1;
			if (state_q == ST_LOAD)
				cnt_q <= CNTW'(QB - 1);
			else if (state_q == ST_DIV)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_q <= e_res;
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					job_q <= rdata;
					sv_q <= rdata.d2;
					sres_q <= '0;
					sbit_q <= 34'd1 << 32;
				end
			end
			ST_SQRT: begin
				sv_q <= sv_n;
				sres_q <= sres_n;
				sbit_q <= sbit_q >> 2;
				if (sbit_q == 34'd1)
					len_q <= sres_n[16:0];
			end
			ST_MUL: begin
				for (int i = 0; i < 6; i++)
					prod_q[i] <= prod_n[i];
			end
			ST_LOAD: begin
				for (int i = 0; i < 6; i++) begin
					neg_q[i] <= prod_q[i][35];
					rem_q[i] <= DW'(mag[i]) + DW'(dvs[i] >> 1);
					dsh_q[i] <= DW'(dvs[i]) << (QB - 1);
					quo_q[i] <= '0;
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 6; i++) begin
					if (rem_q[i] >= dsh_q[i]) begin
						rem_q[i] <= rem_q[i] - dsh_q[i];
						quo_q[i] <= {quo_q[i][QB-2:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][QB-2:0], 1'b0};
					end
					dsh_q[i] <= dsh_q[i] >> 1;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = res_q;

endmodule

>>> hw/rtl/shape_pair_collision_pushback.sv
// top level of the shape pair collision and push-back block
// a no-push result leaves the back-end idle state after the front stages and the queue;
//   box-box records leave the pick state; after the root (17 steps) a lone sphere-side
//   box-sphere record leaves it too, and a radial record passes multiply, load and 19
//   divide steps; a second radial record of the same pair skips the root
// throughput: one pair per cycle while pairs give no records, else the back end paces
// reset: arst_n clears the pipeline valids, queue pointers and back-end state
// the receiver cannot stall: each result shows on done for exactly one cycle
module shape_pair_collision_pushback import spcp_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ID_WIDTH = ID_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	logic           accept, fr_push, q_pop, q_empty;
	job_t           fr_job, q_job;
	logic [1:0]     inflight;
	logic [QCW-1:0] q_count;

	// a transfer happens when start meets a free slot
	assign accept = start && !busy;

	// busy reserves a queue slot for every pair still in the front pipeline
	assign busy = ({1'b0, q_count} + (QCW + 1)'(inflight)) >= (QCW + 1)'(QDEPTH);

	// front: lane decode, overlap tests, record classification
	spcp_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.ID_WIDTH(ID_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.push(fr_push),
		.job(fr_job),
		.inflight(inflight)
	);

	// decouples front from the multi-cycle back end
	spcp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(fr_push),
		.wdata(fr_job),
		.pop(q_pop),
		.rdata(q_job),
		.empty(q_empty),
		.count(q_count)
	);

	// back: length, penetration divisions, one result transfer per record, or one for a pair with none
	spcp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(q_empty),
		.rdata(q_job),
		.pop(q_pop),
		.done(done),
		.result(result)
	);

endmodule

>>> hw/rtl/spcp_checker.sv
// port-level checks for the shape pair collision block and its bind
module spcp_checker import spcp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    done,
	input result_t result
);

	a_info_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.has_info) |-> result.hit)
		else $error("record without hit");

	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.has_info) |-> (result.last && !result.for_side &&
		result.other_id == 16'd0 && result.push_x == 16'sd0 &&
		result.push_y == 16'sd0 && result.push_z == 16'sd0 &&
		result.point_x == 16'sd0 && result.point_y == 16'sd0 &&
		result.point_z == 16'sd0))
		else $error("plain result not cleared");

	a_no_plain_between: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.has_info && !result.last) |=> (!done || result.has_info))
		else $error("plain result inside a record pair");

	a_pair_sides: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.has_info && !result.last) |=>
		(!done || result.for_side != $past(result.for_side)))
		else $error("record pair for the same side");

endmodule

bind shape_pair_collision_pushback spcp_checker u_spcp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.done(done),
	.result(result)
);
